// ===== sv/clap_pkg.sv =====
package clap_pkg;

  // Default longest line, terminator included in the budget
  localparam int LINE_BYTES_DEF = 64;

  // Widest line length carried in a job (largest LINE_BYTES is 64, so 63 bytes)
  localparam int JOB_LEN_W = 6;

  // Depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Terminator characters
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // Input command codes
  localparam logic CMD_BYTE   = 1'b0;
  localparam logic CMD_RESYNC = 1'b1;

  // One unit of work for the back part: a stored line or an empty-line report
  typedef struct packed {
    logic                 bank;
    logic [JOB_LEN_W-1:0] len;
    logic                 empty;
  } job_t;

  // Bank release from back to front once a line has gone out
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  // Read-out sequencer states
  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_SEND
  } back_state_t;

endpackage

// ===== sv/clap_if.sv =====
// Input channel: one received byte or a resync command per beat
interface clap_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] byte_value;

  modport source (output valid, command, byte_value, input ready);
  modport sink   (input valid, command, byte_value, output ready);
endinterface

// Result channel: one byte of a delivered line per beat
interface clap_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       last_of_line;
  logic       empty_line;

  modport source (output valid, line_byte, last_of_line, empty_line, input ready);
  modport sink   (input valid, line_byte, last_of_line, empty_line, output ready);
endinterface

// ===== sv/clap_front.sv =====
module clap_front import clap_pkg::*; #(
  parameter int LINE_BYTES = LINE_BYTES_DEF,
  localparam int AW = $clog2(LINE_BYTES)
) (
  input  logic          clk,
  input  logic          rst_n,
  clap_in_if.sink       in_ch,
  input  logic          q_full,
  output logic          push,
  output job_t          push_job,
  input  rel_t          rel,
  output logic          wr_en,
  output logic [AW:0]   wr_addr,
  output logic [7:0]    wr_data
);

  logic          in_sync_r, in_sync_nxt;
  logic [AW-1:0] len_r, len_nxt;
  logic          bank_r, bank_nxt;
  logic [1:0]    busy_r, busy_nxt;
  logic          acc;
  logic          term;

  // Stall while the bank being filled is still read out, or the queue is full
  assign in_ch.ready = !busy_r[bank_r] && !q_full;
  assign acc         = in_ch.valid && in_ch.ready;
  assign term        = (in_ch.byte_value == CHAR_CR) || (in_ch.byte_value == CHAR_LF);

  assign wr_addr = {bank_r, len_r};
  assign wr_data = in_ch.byte_value;

  // Classify the beat: store, hand a line on, drop or resync
  always_comb begin
    in_sync_nxt = in_sync_r;
    len_nxt     = len_r;
    bank_nxt    = bank_r;
    push        = 1'b0;
    push_job    = '0;
    wr_en       = 1'b0;
    if (acc) begin
      if (in_ch.command == CMD_RESYNC) begin
        in_sync_nxt = 1'b0;
        len_nxt     = '0;
      end else if (!in_sync_r) begin
        if (term) begin
          in_sync_nxt = 1'b1;
        end
        len_nxt = '0;
      end else if (term) begin
        len_nxt = '0;
        if (len_r != '0) begin
          push           = 1'b1;
          push_job.bank  = bank_r;
          push_job.len   = JOB_LEN_W'(len_r);
          push_job.empty = 1'b0;
          bank_nxt       = ~bank_r;
        end else if (in_ch.byte_value == CHAR_LF) begin
          push           = 1'b1;
          push_job.empty = 1'b1;
        end
      end else if (len_r >= AW'(LINE_BYTES - 1)) begin
        // Line too long: drop out of sync and lose the partial line
        in_sync_nxt = 1'b0;
      end else begin
        wr_en   = 1'b1;
        len_nxt = len_r + 1'b1;
      end
    end
  end

  // Track which banks hold a line not yet fully delivered
  always_comb begin
    busy_nxt = busy_r;
    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (push && !push_job.empty) begin
      busy_nxt[bank_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sync_r <= 1'b1;
      len_r     <= '0;
      bank_r    <= 1'b0;
      busy_r    <= '0;
    end else begin
      in_sync_r <= in_sync_nxt;
      len_r     <= len_nxt;
      bank_r    <= bank_nxt;
      busy_r    <= busy_nxt;
    end
  end

endmodule

// ===== sv/clap_job_queue.sv =====
module clap_job_queue import clap_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head,
  output logic empty
);

  job_t         slots_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (PW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slots_r[rp_r];

  // Advance pointers; wrap at the depth
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Hold job payload
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wp_r] <= push_job;
    end
  end

endmodule

// ===== sv/clap_back.sv =====
module clap_back import clap_pkg::*; #(
  parameter int LINE_BYTES = LINE_BYTES_DEF,
  localparam int AW = $clog2(LINE_BYTES)
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  job_t        q_head,
  output logic        pop,
  output rel_t        rel,
  input  logic        wr_en,
  input  logic [AW:0] wr_addr,
  input  logic [7:0]  wr_data,
  clap_out_if.source  out_ch
);

  // Two line banks: the front fills one while this side reads the other
  logic [7:0]    mem [2**(AW+1)];

  back_state_t   state_r, state_nxt;
  job_t          job_r, job_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          last_r, last_nxt;
  logic          empty_r, empty_nxt;
  logic [7:0]    byte_r;
  logic          load_empty;
  logic          at_last;

  assign at_last = (JOB_LEN_W'(idx_r) + JOB_LEN_W'(1)) == job_r.len;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          state_nxt = q_head.empty ? B_SEND : B_READ;
        end
      end
      B_READ: state_nxt = B_SEND;
      B_SEND: begin
        if (out_ch.ready) begin
          state_nxt = last_r ? B_IDLE : B_READ;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Outputs and datapath control
  always_comb begin
    pop        = 1'b0;
    rel        = '0;
    load_empty = 1'b0;
    job_nxt    = job_r;
    idx_nxt    = idx_r;
    last_nxt   = last_r;
    empty_nxt  = empty_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          pop     = 1'b1;
          job_nxt = q_head;
          idx_nxt = '0;
          if (q_head.empty) begin
            load_empty = 1'b1;
            last_nxt   = 1'b1;
            empty_nxt  = 1'b1;
          end
        end
      end
      B_READ: begin
        last_nxt  = at_last;
        empty_nxt = 1'b0;
      end
      B_SEND: begin
        if (out_ch.ready) begin
          if (last_r) begin
            rel.valid = !empty_r;
            rel.bank  = job_r.bank;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r   <= job_nxt;
    idx_r   <= idx_nxt;
    last_r  <= last_nxt;
    empty_r <= empty_nxt;
  end

  // Line store: write from the front, registered read into the result
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (state_r == B_READ) begin
      byte_r <= mem[{job_r.bank, idx_r}];
    end else if (load_empty) begin
      byte_r <= '0;
    end
  end

  assign out_ch.valid        = (state_r == B_SEND);
  assign out_ch.line_byte    = byte_r;
  assign out_ch.last_of_line = last_r;
  assign out_ch.empty_line   = empty_r;

endmodule

// ===== sv/crlf_line_assembler.sv =====
// CR/LF line assembler. Each beat on the input channel carries a received byte or a
// resync command, and the front part takes one beat per cycle: bytes are written
// into one of two line banks, and a CR or LF hands the finished line to a
// two-entry job queue. A lone LF queues an empty-line report (byte 0, last and
// empty set); a lone CR gives nothing. A line that reaches LINE_BYTES-1 bytes and
// gets one more byte drops sync, and bytes are then discarded until the next
// terminator; the resync command drops sync as well. The back part takes a job
// from the queue in its idle state, then reads the line out of its bank by
// alternating a read state (the registered memory read) with a send state (the
// result beat); an empty-line report goes from the idle state straight to the
// send state with no read. Input stalls only while the queue is full or the bank
// about to be filled is still being read out. The line store needs no clearing
// after reset.
module crlf_line_assembler import clap_pkg::*; #(
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  clap_in_if.sink    in_ch,
  clap_out_if.source out_ch
);

  localparam int AW = $clog2(LINE_BYTES);

  logic        q_full;
  logic        q_empty;
  logic        push;
  logic        pop;
  job_t        push_job;
  job_t        q_head;
  rel_t        rel;
  logic        wr_en;
  logic [AW:0] wr_addr;
  logic [7:0]  wr_data;

  clap_front #(.LINE_BYTES(LINE_BYTES)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job),
    .rel      (rel),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  clap_job_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  clap_back #(.LINE_BYTES(LINE_BYTES)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .pop     (pop),
    .rel     (rel),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .out_ch  (out_ch)
  );

endmodule

// ===== sv/clap_checker.sv =====
module clap_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic       out_empty
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last) && $stable(out_empty))
    else $error("stalled result payload changed");

  // An empty-line report is a single closing beat carrying zero
  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty |-> out_last && (out_byte == 8'h00))
    else $error("malformed empty-line beat");

  // Drop any result during reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat straight after reset");

endmodule

bind crlf_line_assembler clap_checker u_clap_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.line_byte),
  .out_last  (out_ch.last_of_line),
  .out_empty (out_ch.empty_line)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import clap_pkg::*;

  // Longest line the store keeps; one more plain byte drops sync
  localparam int LINE_LIMIT  = LINE_BYTES_DEF - 1;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 3000;
  localparam int PHASE_ITEMS = 85;

  typedef struct packed {
    logic       cmd;
    logic [7:0] value;
  } rx_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       empty;
  } line_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  clap_in_if  in_ch ();
  clap_out_if out_ch ();

  crlf_line_assembler u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  rx_beat_t   rx_pending[$];
  line_beat_t line_expect[$];
  rx_beat_t   next_beat;
  line_beat_t want_beat;

  // Line assembly state as the block should hold it
  logic       asm_synced;
  logic [6:0] asm_len;
  logic [7:0] asm_store [0:63];

  int idle_pct;
  int stall_pct;
  int hold_ask;
  int hold_seen;
  int hold_left;
  int fail_count;
  int quiet_cycles;
  int gen_count;

  task automatic report_error(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  // Work out the line beats one accepted input beat causes
  task automatic assemble_line(input logic cmd, input logic [7:0] value);
    logic is_term;
    is_term = (value == CHAR_CR) || (value == CHAR_LF);
    if (cmd == CMD_RESYNC) begin
      asm_synced = 1'b0;
      asm_len    = '0;
    end else if (!asm_synced) begin
      if (is_term) asm_synced = 1'b1;
      asm_len = '0;
    end else if (is_term) begin
      if (asm_len != 0) begin
        for (int i = 0; i < asm_len; i++)
          line_expect.push_back('{data: asm_store[i], last: (i + 1 == asm_len), empty: 1'b0});
      end else if (value == CHAR_LF) begin
        line_expect.push_back('{data: 8'h00, last: 1'b1, empty: 1'b1});
      end
      asm_len = '0;
    end else if (asm_len >= LINE_LIMIT) begin
      asm_synced = 1'b0;
    end else begin
      asm_store[asm_len[5:0]] = value;
      asm_len++;
    end
  endtask

  // Driver: predict on each accepted beat, then offer the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        assemble_line(in_ch.command, in_ch.byte_value);
      if (!in_ch.valid || in_ch.ready) begin
        if (rx_pending.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          next_beat = rx_pending.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.command    <= next_beat.cmd;
          in_ch.byte_value <= next_beat.value;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result beat, then pick ready, honouring a long hold-off
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (line_expect.size() == 0) begin
        report_error($sformatf("line byte %02h with nothing expected", out_ch.line_byte));
      end else begin
        want_beat = line_expect.pop_front();
        if (out_ch.line_byte !== want_beat.data)
          report_error($sformatf("line_byte %02h, want %02h", out_ch.line_byte, want_beat.data));
        if (out_ch.last_of_line !== want_beat.last)
          report_error($sformatf("last_of_line %b, want %b", out_ch.last_of_line,
                                 want_beat.last));
        if (out_ch.empty_line !== want_beat.empty)
          report_error($sformatf("empty_line %b, want %b", out_ch.empty_line, want_beat.empty));
      end
    end
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_seen != hold_ask) begin
      out_ch.ready <= 1'b0;
      hold_seen    <= hold_ask;
      hold_left    <= HOLD_CYCLES;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog: end the run once no beat moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Queue one input beat; beats the block will merely discard are not counted
  task automatic put(input logic cmd, input logic [7:0] value, input bit counts);
    rx_pending.push_back('{cmd: cmd, value: value});
    if (counts) gen_count++;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CHAR_CR || b == CHAR_LF);
    return b;
  endfunction

  // End a line with CR, LF or the pair
  task automatic put_terminator();
    case ($urandom_range(0, 2))
      0: put(CMD_BYTE, CHAR_CR, 1);
      1: put(CMD_BYTE, CHAR_LF, 1);
      default: begin
        put(CMD_BYTE, CHAR_CR, 1);
        put(CMD_BYTE, CHAR_LF, 1);
      end
    endcase
  endtask

  // A line of n plain bytes; past the limit the tail is dropped unsynced
  task automatic put_line(input int n);
    for (int i = 0; i < n; i++)
      put(CMD_BYTE, plain_byte(), i <= LINE_LIMIT);
    put_terminator();
  endtask

  task automatic put_random_part();
    int r;
    while (gen_count < PHASE_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // resync, noise while unsynced, then a terminator to recover
        put(CMD_RESYNC, 8'($urandom_range(0, 255)), 1);
        repeat ($urandom_range(0, 4)) put(CMD_BYTE, 8'($urandom_range(0, 255)), 0);
        put(CMD_BYTE, $urandom_range(0, 1) ? CHAR_CR : CHAR_LF, 1);
      end else if (r < 12) begin
        // line broken by a resync
        repeat ($urandom_range(1, 5)) put(CMD_BYTE, plain_byte(), 1);
        put(CMD_RESYNC, 8'($urandom_range(0, 255)), 1);
        put(CMD_BYTE, CHAR_LF, 1);
      end else if (r < 15) begin
        put_line(LINE_LIMIT);
      end else if (r < 18) begin
        put_line($urandom_range(LINE_LIMIT + 1, LINE_LIMIT + 4));
      end else if (r < 34) begin
        put_line($urandom_range(7, 40));
      end else begin
        put_line($urandom_range(0, 6));
      end
    end
    gen_count = 0;
  endtask

  // Hold until every queued beat is taken and every line byte has come
  task automatic wait_drained();
    @(posedge clk);
    while (rx_pending.size() != 0 || in_ch.valid || line_expect.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.command    = CMD_BYTE;
    in_ch.byte_value = 8'h00;
    out_ch.ready     = 1'b0;
    asm_synced       = 1'b1;
    asm_len          = '0;
    idle_pct         = 0;
    stall_pct        = 0;
    hold_ask         = 0;
    hold_seen        = 0;
    hold_left        = 0;
    fail_count       = 0;
    quiet_cycles     = 0;
    gen_count        = 0;

    // Directed: lone LF, lone CR, extreme bytes, CR LF pair, resync paths
    put(CMD_BYTE, CHAR_LF, 1);
    put(CMD_BYTE, CHAR_CR, 1);
    put(CMD_BYTE, 8'h00, 1);
    put(CMD_BYTE, 8'hFF, 1);
    put(CMD_BYTE, CHAR_CR, 1);
    put(CMD_BYTE, 8'h41, 1);
    put(CMD_BYTE, CHAR_LF, 1);
    put(CMD_BYTE, 8'h42, 1);
    put(CMD_BYTE, CHAR_CR, 1);
    put(CMD_BYTE, CHAR_LF, 1);
    put(CMD_RESYNC, 8'hFF, 1);
    put(CMD_BYTE, 8'h78, 0);
    put(CMD_BYTE, CHAR_CR, 1);
    put(CMD_BYTE, 8'h55, 1);
    put(CMD_BYTE, 8'hAA, 1);
    put(CMD_BYTE, CHAR_LF, 1);
    put(CMD_RESYNC, CHAR_LF, 1);
    put(CMD_BYTE, CHAR_LF, 1);
    put(CMD_BYTE, CHAR_LF, 1);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    wait_drained();

    // Phase with no idling: full line, overflow, then a long receiver hold-off
    gen_count = 0;
    put_line(LINE_LIMIT);
    put_line(LINE_LIMIT + 1);
    put(CMD_BYTE, CHAR_LF, 1);
    put_random_part();
    hold_ask <= hold_ask + 1;
    wait_drained();

    // Sender idle in just over half the cycles
    idle_pct <= 54;
    put_random_part();
    wait_drained();

    // Receiver stalling in just over half the cycles
    idle_pct  <= 0;
    stall_pct <= 54;
    put_random_part();
    wait_drained();

    // Both sides idling lightly
    idle_pct  <= 8;
    stall_pct <= 8;
    put_random_part();
    wait_drained();

    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/clap_pkg.sv
sv/clap_if.sv
sv/clap_front.sv
sv/clap_job_queue.sv
sv/clap_back.sv
sv/crlf_line_assembler.sv
sv/clap_checker.sv
tb/sv/tb.sv
